@@ rtl/thm_pkg.sv @@
// Package for the tag Hamming-one matcher: shared constants, codes and the
// control struct that travels down the cell chain. No dependencies.

package thm_pkg;

  // Default sizes of the tag table.
  localparam int DEF_TAG_BASES   = 15;
  localparam int DEF_TABLE_DEPTH = 64;

  // Fixed field widths of the channels.
  localparam int FUNC_W   = 1;
  localparam int IDX_W    = 6;
  localparam int BASES_W  = 45;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 7;

  // Base code for N, the only legal code above T.
  localparam logic [2:0] BASE_N = 3'd4;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD   = 1'b0,
    FN_LOOKUP = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_BASE = 2'd1,
    ST_LOAD_N   = 2'd2
  } status_t;

  // Control and partial result carried by one beat through the chain.
  typedef struct packed {
    logic             vld;
    logic             lookup;
    logic             wr;
    logic [IDX_W-1:0] entry;
    logic             found;
    logic [IDX_W-1:0] idx;
    status_t          status;
  } ctl_t;

endpackage

@@ rtl/thm_if.sv @@
// Channel interfaces of the tag Hamming-one matcher: input, result and
// configuration. Depends on thm_pkg for the field widths.

interface thm_in_if;
  logic                         valid;
  logic                         ready;
  logic [thm_pkg::FUNC_W-1:0]   func;
  logic [thm_pkg::IDX_W-1:0]    entry_index;
  logic [thm_pkg::BASES_W-1:0]  tag_bases;

  modport source (output valid, func, entry_index, tag_bases, input ready);
  modport sink   (input valid, func, entry_index, tag_bases, output ready);
endinterface

interface thm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [thm_pkg::IDX_W-1:0]    match_index;
  logic [thm_pkg::STATUS_W-1:0] status;

  modport source (output valid, found, match_index, status, input ready);
  modport sink   (input valid, found, match_index, status, output ready);
endinterface

interface thm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [thm_pkg::CNT_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/thm_cell.sv @@
// One cell of the matcher chain: holds one stored tag, writes it on a load
// addressed to it and compares passing queries against it. Uses thm_pkg.

module thm_cell #(
  parameter int TAG_BASES = thm_pkg::DEF_TAG_BASES,
  parameter int CELL_IDX  = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [thm_pkg::CNT_W-1:0] tag_count,
  input  thm_pkg::ctl_t             ctl_i,
  input  logic [3*TAG_BASES-1:0]    query_i,
  output thm_pkg::ctl_t             ctl_o,
  output logic [3*TAG_BASES-1:0]    query_o
);
  import thm_pkg::*;

  localparam int QW = 3 * TAG_BASES;
  localparam int SW = 2 * TAG_BASES;
  localparam bit ADDRESSABLE = CELL_IDX < (1 << IDX_W);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [SW-1:0]        tag_r;
  logic [SW-1:0]        packed_tag;
  logic [QW-1:0]        query_r;
  logic                 vld_r;
  ctl_t                 ctl_r;
  ctl_t                 ctl_nxt;
  logic [TAG_BASES-1:0] miss;
  logic                 hit;
  logic                 in_use;
  logic                 wr_here;

  // Per-base compare; an N in the query never equals a stored base.
  always_comb begin
    for (int p = 0; p < TAG_BASES; p++) begin
      miss[p]           = query_i[3*p +: 3] != {1'b0, tag_r[2*p +: 2]};
      packed_tag[2*p +: 2] = query_i[3*p +: 2];
    end
    hit     = (miss & (miss - TAG_BASES'(1))) == '0;
    in_use  = int'(tag_count) > CELL_IDX;
    wr_here = ADDRESSABLE && ctl_i.vld && ctl_i.wr && (ctl_i.entry == MY_IDX);
  end

  // A later cell overwrites an earlier hit, so the highest index wins.
  always_comb begin
    ctl_nxt = ctl_i;
    if (ctl_i.vld && ctl_i.lookup && in_use && hit) begin
      ctl_nxt.found = 1'b1;
      ctl_nxt.idx   = MY_IDX;
    end
  end

  // Beat valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= ctl_nxt.vld;
    end
  end

  // Beat payload and stored tag.
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r   <= ctl_nxt;
      query_r <= query_i;
      if (wr_here) begin
        tag_r <= packed_tag;
      end
    end
  end

  always_comb begin
    ctl_o     = ctl_r;
    ctl_o.vld = vld_r;
  end

  assign query_o = query_r;

endmodule

@@ rtl/tag_hamming_one_matcher.sv @@
// Top level of the tag Hamming-one matcher: input check, chain of thm_cell
// instances and the configuration register. Uses thm_pkg and thm_if.

// Every beat, load or lookup, walks a chain of TABLE_DEPTH cells, one cell
// per cycle while the chain advances; cell i holds table entry i. The chain
// takes one beat per cycle while the result is taken or the chain has room,
// so loads and lookups keep their order and a lookup sees every earlier
// load. The length of the cell chain sets the latency. When the result is
// not taken the chain holds; the first cell still takes a beat while it is
// empty. tag_count may only be written while no beat is in the chain.

module tag_hamming_one_matcher #(
  parameter int TAG_BASES   = thm_pkg::DEF_TAG_BASES,
  parameter int TABLE_DEPTH = thm_pkg::DEF_TABLE_DEPTH
) (
  input logic       clk,
  input logic       rst_n,
  thm_in_if.sink    in_ch,
  thm_out_if.source out_ch,
  thm_cfg_if.sink   cfg_ch
);
  import thm_pkg::*;

  localparam int QW  = 3 * TAG_BASES;
  localparam int PAD = QW + BASES_W;

  logic [CNT_W-1:0] tag_count_r;
  logic [PAD-1:0]   bases_wide;
  logic [QW-1:0]    query_in;
  logic             bad_base;
  logic             has_n;
  ctl_t             ctl_in;
  logic             adv;
  logic             en0;

  ctl_t          chain_ctl [0:TABLE_DEPTH];
  logic [QW-1:0] chain_q   [0:TABLE_DEPTH];

  // Configuration register.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_count_r <= '0;
    end else if (cfg_ch.valid) begin
      tag_count_r <= cfg_ch.data;
    end
  end

  // Take the bases in use; bases beyond the field read as A.
  assign bases_wide = PAD'(in_ch.tag_bases);
  assign query_in   = bases_wide[QW-1:0];

  // Scan for illegal codes and for N.
  always_comb begin
    bad_base = 1'b0;
    has_n    = 1'b0;
    for (int p = 0; p < TAG_BASES; p++) begin
      if (query_in[3*p +: 3] > BASE_N) begin
        bad_base = 1'b1;
      end
      if (query_in[3*p +: 3] == BASE_N) begin
        has_n = 1'b1;
      end
    end
  end

  // Build the beat that enters the chain.
  always_comb begin
    ctl_in.vld   = in_ch.valid;
    ctl_in.entry = in_ch.entry_index;
    ctl_in.found = 1'b0;
    ctl_in.idx   = '0;
    if (bad_base) begin
      ctl_in.status = ST_BAD_BASE;
    end else if ((in_ch.func == FN_LOAD) && has_n) begin
      ctl_in.status = ST_LOAD_N;
    end else begin
      ctl_in.status = ST_OK;
    end
    ctl_in.wr     = (in_ch.func == FN_LOAD) && (ctl_in.status == ST_OK);
    ctl_in.lookup = (in_ch.func == FN_LOOKUP) && (ctl_in.status == ST_OK);
  end

  // Chain advance: all cells move unless the result waits; cell 0 also fills
  // when it is empty.
  assign adv         = !chain_ctl[TABLE_DEPTH].vld || out_ch.ready;
  assign en0         = adv || !chain_ctl[1].vld;
  assign in_ch.ready = en0;

  assign chain_ctl[0] = ctl_in;
  assign chain_q[0]   = query_in;

  // Row of cells, one table entry each.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic cell_en;
    if (g == 0) begin : g_first
      assign cell_en = en0;
    end else begin : g_rest
      assign cell_en = adv;
    end

    thm_cell #(
      .TAG_BASES (TAG_BASES),
      .CELL_IDX  (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (cell_en),
      .tag_count (tag_count_r),
      .ctl_i     (chain_ctl[g]),
      .query_i   (chain_q[g]),
      .ctl_o     (chain_ctl[g+1]),
      .query_o   (chain_q[g+1])
    );
  end

  // The last cell's register is the result register.
  assign out_ch.valid       = chain_ctl[TABLE_DEPTH].vld;
  assign out_ch.found       = chain_ctl[TABLE_DEPTH].found;
  assign out_ch.match_index = chain_ctl[TABLE_DEPTH].idx;
  assign out_ch.status      = chain_ctl[TABLE_DEPTH].status;

endmodule

@@ rtl/thm_checker.sv @@
// Port checker for the tag Hamming-one matcher and its bind to the top
// level. Uses thm_pkg for the status codes and field widths.

module thm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_found,
  input logic [thm_pkg::IDX_W-1:0]    out_match_index,
  input logic [thm_pkg::STATUS_W-1:0] out_status
);
  import thm_pkg::*;

  // A result beat stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_BAD_BASE ||
                   out_status == ST_LOAD_N))
    else $error("undefined status code on result");

  // A match is only reported for a clean lookup.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("match reported with error status");

  // A missing match or an error always reports index zero.
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_index == '0)
    else $error("nonzero index without a match");

endmodule

bind tag_hamming_one_matcher thm_checker u_thm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_found       (out_ch.found),
  .out_match_index (out_ch.match_index),
  .out_status      (out_ch.status)
);
